// ===== design/qhcc_pkg.sv =====
// Package of shared types and constants for the QUIC header connection-ID classifier.
package qhcc_pkg;

  localparam int MAX_CID_LEN        = 20;
  localparam int MAX_DATAGRAM_BYTES = 65535;
  localparam int POS_W              = 16;
  localparam int CMP_W              = POS_W + 1;
  localparam int CID_IDX_W          = 5;
  localparam int CID_LEN_W          = 5;
  localparam int VERSION_W          = 32;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 32;
  localparam int LONG_FORM_BIT      = 7;
  localparam int LONG_MIN_BYTES     = 7;
  localparam int SHORT_DEFAULT_LEN  = 8;
  localparam int LONG_VERSION_LAST  = 4;
  localparam int LONG_DCID_LEN_POS  = 5;
  localparam int QUEUE_DEPTH        = 4;
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_CID_LENGTH = 1'b0,
    CFG_ACCEPTED_VERSION = 1'b1
  } qhcc_cfg_idx_e;

  typedef enum logic {
    KIND_CID     = 1'b0,
    KIND_VERDICT = 1'b1
  } qhcc_kind_e;

  typedef enum logic {
    CID_DEST = 1'b0,
    CID_SRC  = 1'b1
  } qhcc_cid_sel_e;

  typedef enum logic [1:0] {
    VERD_MALFORMED   = 2'd0,
    VERD_VERSION_NEG = 2'd1,
    VERD_LONG_OK     = 2'd2,
    VERD_SHORT       = 2'd3
  } qhcc_verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } qhcc_in_t;

  typedef struct packed {
    qhcc_kind_e             item_kind;
    qhcc_cid_sel_e          cid_select;
    logic [CID_IDX_W-1:0]   cid_index;
    logic [7:0]             cid_byte;
    qhcc_verdict_e          verdict;
    logic [1:0]             long_type;
    logic [VERSION_W-1:0]   version_seen;
    logic [CID_LEN_W-1:0]   dcid_length;
    logic [CID_LEN_W-1:0]   scid_length;
    logic                   last_of_run;
  } qhcc_out_t;

  typedef struct packed {
    logic                   has_cid;
    qhcc_cid_sel_e          cid_select;
    logic [CID_IDX_W-1:0]   cid_index;
    logic [7:0]             cid_byte;
    logic                   has_verdict;
    qhcc_verdict_e          verdict;
    logic [1:0]             long_type;
    logic [VERSION_W-1:0]   version_seen;
    logic [CID_LEN_W-1:0]   dcid_length;
    logic [CID_LEN_W-1:0]   scid_length;
  } qhcc_run_t;

endpackage

// ===== design/qhcc_front.sv =====
// Front end: configuration registers, per-byte header parsing and verdict classification.
module qhcc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qhcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qhcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qhcc_pkg::qhcc_in_t          in_data_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output qhcc_pkg::qhcc_run_t         run_o
);
  import qhcc_pkg::*;

  logic [CID_LEN_W-1:0] short_len_q;
  logic [VERSION_W-1:0] acc_ver_q;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [7:0]           first_q, first_d;
  logic [VERSION_W-1:0] ver_q, ver_d;
  logic [7:0]           dlen_q, dlen_d;
  logic [7:0]           slen_q, slen_d;
  logic                 bad_q, bad_d;
  logic                 accept;
  logic [CID_LEN_W-1:0] eff_len;
  qhcc_run_t            run;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= CID_LEN_W'(SHORT_DEFAULT_LEN);
      acc_ver_q   <= VERSION_W'(1);
    end else if (cfg_we_i) begin
      unique case (qhcc_cfg_idx_e'(cfg_index_i))
        CFG_SHORT_CID_LENGTH: short_len_q <= cfg_data_i[CID_LEN_W-1:0];
        CFG_ACCEPTED_VERSION: acc_ver_q   <= cfg_data_i[VERSION_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (short_len_q == '0 || short_len_q > CID_LEN_W'(MAX_CID_LEN)) begin
      eff_len = CID_LEN_W'(SHORT_DEFAULT_LEN);
    end else begin
      eff_len = short_len_q;
    end
  end

  always_comb begin
    logic [CMP_W-1:0] p;
    logic [CMP_W-1:0] d;
    logic [CMP_W-1:0] s;
    logic             oversize;
    logic [7:0]       b;
    logic             malformed;

    b        = in_data_i.data_byte;
    p        = {1'b0, pos_q};
    oversize = pos_q >= POS_W'(MAX_DATAGRAM_BYTES);
    first_d  = first_q;
    ver_d    = ver_q;
    dlen_d   = dlen_q;
    slen_d   = slen_q;
    bad_d    = bad_q;
    pos_d    = pos_q;
    run      = '0;
    d        = CMP_W'(dlen_q);

    if (!oversize) begin
      if (pos_q == '0) begin
        first_d = b;
      end else if (first_q[LONG_FORM_BIT]) begin
        if (p <= CMP_W'(LONG_VERSION_LAST)) begin
          ver_d = {ver_q[VERSION_W-9:0], b};
        end else if (p == CMP_W'(LONG_DCID_LEN_POS)) begin
          dlen_d = b;
          if (b > 8'(MAX_CID_LEN)) bad_d = 1'b1;
        end else if (!bad_q) begin
          if (p < CMP_W'(LONG_MIN_BYTES - 1) + d) begin
            run.has_cid    = 1'b1;
            run.cid_select = CID_DEST;
            run.cid_index  = CID_IDX_W'(p - CMP_W'(LONG_MIN_BYTES - 1));
            run.cid_byte   = b;
          end else if (p == CMP_W'(LONG_MIN_BYTES - 1) + d) begin
            slen_d = b;
            if (b > 8'(MAX_CID_LEN)) bad_d = 1'b1;
          end else if (p < CMP_W'(LONG_MIN_BYTES) + d + CMP_W'(slen_q)) begin
            run.has_cid    = 1'b1;
            run.cid_select = CID_SRC;
            run.cid_index  = CID_IDX_W'(p - CMP_W'(LONG_MIN_BYTES) - d);
            run.cid_byte   = b;
          end
        end
      end else if (p <= CMP_W'(eff_len)) begin
        run.has_cid    = 1'b1;
        run.cid_select = CID_DEST;
        run.cid_index  = CID_IDX_W'(p - CMP_W'(1));
        run.cid_byte   = b;
      end
      pos_d = pos_q + POS_W'(1);
    end

    d = CMP_W'(dlen_d);
    s = CMP_W'(slen_d);
    if (first_d[LONG_FORM_BIT]) begin
      malformed = oversize || p < CMP_W'(LONG_MIN_BYTES - 1) || bad_d ||
                  p < CMP_W'(LONG_MIN_BYTES - 1) + d + s;
      if (!malformed) begin
        run.verdict      = (ver_d == acc_ver_q) ? VERD_LONG_OK : VERD_VERSION_NEG;
        run.long_type    = first_d[5:4];
        run.version_seen = ver_d;
        run.dcid_length  = dlen_d[CID_LEN_W-1:0];
        run.scid_length  = slen_d[CID_LEN_W-1:0];
      end
    end else begin
      malformed = oversize || p < CMP_W'(eff_len);
      if (!malformed) begin
        run.verdict     = VERD_SHORT;
        run.dcid_length = eff_len;
      end
    end
    run.has_verdict = in_data_i.end_of_datagram;
    if (!in_data_i.end_of_datagram) begin
      run.verdict      = VERD_MALFORMED;
      run.long_type    = '0;
      run.version_seen = '0;
      run.dcid_length  = '0;
      run.scid_length  = '0;
    end
  end

  assign push_o = accept && (run.has_cid || run.has_verdict);
  assign run_o  = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= '0;
      ver_q   <= '0;
      dlen_q  <= '0;
      slen_q  <= '0;
      bad_q   <= 1'b0;
    end else if (accept) begin
      if (in_data_i.end_of_datagram) begin
        pos_q   <= '0;
        first_q <= '0;
        ver_q   <= '0;
        dlen_q  <= '0;
        slen_q  <= '0;
        bad_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        first_q <= first_d;
        ver_q   <= ver_d;
        dlen_q  <= dlen_d;
        slen_q  <= slen_d;
        bad_q   <= bad_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_datagram |=> pos_q == '0 && !bad_q)
    else $error("Datagram state not cleared after the final byte.");

endmodule

// ===== design/qhcc_fifo.sv =====
// Short queue of per-byte result runs between the front end and the back end.
module qhcc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qhcc_pkg::qhcc_run_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output qhcc_pkg::qhcc_run_t head_o
);
  import qhcc_pkg::*;

  qhcc_run_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;
  logic                   do_pop;

  assign full_o  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QUEUE_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QUEUE_CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Queue written while full.");

endmodule

// ===== design/qhcc_back.sv =====
// Back end: splits each queued run into result transfers and holds the output register.
module qhcc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  qhcc_pkg::qhcc_run_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qhcc_pkg::qhcc_out_t out_data_o
);
  import qhcc_pkg::*;

  logic      out_valid_q;
  qhcc_out_t out_q, out_d;
  logic      pend_q, pend_d;
  logic      load;
  logic      cid_first;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign cid_first = head_i.has_cid && !pend_q;

  always_comb begin
    out_d = '0;
    if (cid_first) begin
      out_d.item_kind   = KIND_CID;
      out_d.cid_select  = head_i.cid_select;
      out_d.cid_index   = head_i.cid_index;
      out_d.cid_byte    = head_i.cid_byte;
      out_d.last_of_run = !head_i.has_verdict;
    end else begin
      out_d.item_kind    = KIND_VERDICT;
      out_d.verdict      = head_i.verdict;
      out_d.long_type    = head_i.long_type;
      out_d.version_seen = head_i.version_seen;
      out_d.dcid_length  = head_i.dcid_length;
      out_d.scid_length  = head_i.scid_length;
      out_d.last_of_run  = 1'b1;
    end
    pend_d = cid_first && head_i.has_verdict;
  end

  assign pop_o = load && !pend_d;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pend_q      <= pend_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> head_valid_i)
    else $error("Pending verdict lost its queue entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.item_kind == KIND_VERDICT |-> out_q.last_of_run)
    else $error("Verdict transfer not marked as last of its run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.item_kind == KIND_CID && !out_q.last_of_run |-> pend_q)
    else $error("Connection-ID byte promises a verdict that is not pending.");

endmodule

// ===== design/quic_header_cid_classifier.sv =====
// Top level of the QUIC header connection-ID classifier.
//
// Datagram bytes enter on the in channel, one transfer per byte, with
// end_of_datagram set on the final byte. Each connection-ID byte leaves on
// the out channel as a result transfer, and the final byte also yields a
// verdict transfer; last_of_run marks the final result caused by a byte.
// The front end accepts one byte per cycle while the queue has room and
// pushes its results into a four-entry queue; the back end drains that
// queue into the output register, so a result passes through a queue entry
// and then the output register. A final byte that also carries a
// connection-ID byte yields two output transfers, which the queue absorbs.
// When the receiver stalls, the output register holds and the queue fills;
// in_ready_o falls once the queue is full and rises as soon as it drains.
// The configuration port writes short_cid_length (index 0) or
// accepted_version (index 1), with no read-back.
// Reset empties the queue and output register, clears the datagram state
// and sets the registers to a short length of 8 and version 1.
module quic_header_cid_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qhcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qhcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  qhcc_pkg::qhcc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output qhcc_pkg::qhcc_out_t             out_data_o
);
  import qhcc_pkg::*;

  logic      push;
  qhcc_run_t push_run;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  qhcc_run_t head;

  qhcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .run_o        (push_run)
  );

  qhcc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  qhcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
